[hw/rtl/spr_pkg.sv]
package spr_pkg;

  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_OWN  = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;

  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic       append_here;
    logic       use_rep;
    logic       compare_en;
  } cell_ctrl_t;

endpackage

[hw/rtl/spr_cell.sv]
module spr_cell (
  input  logic               clk,
  input  spr_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         in_byte,
  input  logic [7:0]         rep_byte,
  input  logic [7:0]         pat_byte,
  input  logic               match_in,
  input  logic [7:0]         staged_next,
  output logic [7:0]         staged,
  output logic               match_out
);
  import spr_pkg::*;

  logic [7:0] cur;
  logic [7:0] wnd;

  assign wnd       = ctrl.append_here ? in_byte : cur;
  assign staged    = ctrl.use_rep ? rep_byte : wnd;
  assign match_out = match_in & (~ctrl.compare_en | (wnd == pat_byte));

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      CMD_OWN:  cur <= staged;
      CMD_NEXT: cur <= staged_next;
      default:  cur <= cur;
    endcase
  end

endmodule

[hw/rtl/stream_pattern_replace.sv]
// Channel   Direction  Signals                                   Payload
// s_*       in         s_tvalid s_tready s_tdata s_tuser s_tlast  byte, has-byte flag, end of text
// m_*       out        m_tvalid m_tready m_tdata m_tuser m_tlast  byte, has-byte/run-last, end of text
// cfg_*     in         cfg_we cfg_index cfg_data                  register writes
//
// An input transaction that gives at most one result is taken every cycle while
// the output is not stalled. One that gives n results holds s_tready low while
// the cell row shifts the pending bytes out through cell 0, one per cycle unless stalled.
// Reset is synchronous and clears the counters and the output valid; the
// window contents are undefined until written. A low m_tready holds the
// output register and stops the row.
module stream_pattern_replace #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] in_has_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [0] out_has_byte, [1] run_last
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import spr_pkg::*;

  localparam int DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;

  logic [CW-1:0] count;
  logic [CW-1:0] emit_left;
  logic          end_pend;

  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_has_byte;
  logic          run_last;
  logic          text_end;

  logic [3:0]    plen4;
  logic [3:0]    rlen4;
  logic [CW-1:0] plen;
  logic [CW-1:0] rlen;
  logic [CW-1:0] cnt1;
  logic [CW-1:0] emit;
  logic [CW-1:0] keep;
  logic          use_rep;
  logic          marker;
  logic          result_now;
  logic          single;
  logic          advance;
  logic          accept;
  logic          drain_step;

  cell_ctrl_t    ctrl   [DEPTH];
  logic [7:0]    staged [DEPTH];
  logic [DEPTH:0] match_chain;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= 64'd0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= 64'd0;
      replacement_length <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == 4'd0) begin
      plen4 = 4'd1;
    end else if (pattern_length > 4'(MAX_PATTERN)) begin
      plen4 = 4'(MAX_PATTERN);
    end else begin
      plen4 = pattern_length;
    end
    if (replacement_length > 4'(MAX_REPLACEMENT)) begin
      rlen4 = 4'(MAX_REPLACEMENT);
    end else begin
      rlen4 = replacement_length;
    end
  end

  assign plen = CW'(plen4);
  assign rlen = CW'(rlen4);
  assign cnt1 = count + CW'(s_tuser);

  assign advance    = ~out_valid | m_tready;
  assign s_tready   = (emit_left == '0) & advance;
  assign accept     = s_tvalid & s_tready;
  assign drain_step = (emit_left != '0) & advance;

  always_comb begin
    use_rep = 1'b0;
    emit    = '0;
    keep    = cnt1;
    if (s_tuser) begin
      if (cnt1 > plen) begin
        emit = cnt1 - plen;
        keep = plen;
      end else if (cnt1 == plen) begin
        if (match_chain[DEPTH]) begin
          use_rep = 1'b1;
          emit    = rlen;
          keep    = '0;
        end else begin
          emit = CW'(1);
          keep = plen - CW'(1);
        end
      end
    end
    if (s_tlast) begin
      emit = emit + keep;
      keep = '0;
    end
  end

  assign marker     = s_tlast & (emit == '0);
  assign result_now = (emit != '0) | marker;
  assign single     = (emit == CW'(1)) | marker;

  assign match_chain[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] nb;

    if (i == DEPTH - 1) begin : g_tail
      assign nb = 8'h00;
    end else begin : g_body
      assign nb = staged[i+1];
    end

    always_comb begin
      ctrl[i].append_here = accept & s_tuser & (count == CW'(i));
      ctrl[i].use_rep     = accept & use_rep;
      ctrl[i].compare_en  = CW'(i) < plen;
      if (accept) begin
        ctrl[i].cmd = (emit != '0) ? CMD_NEXT : CMD_OWN;
      end else if (drain_step) begin
        ctrl[i].cmd = CMD_NEXT;
      end else begin
        ctrl[i].cmd = CMD_HOLD;
      end
    end

    spr_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .in_byte     (s_tdata),
      .rep_byte    (replacement_bytes[8*i +: 8]),
      .pat_byte    (pattern_bytes[8*i +: 8]),
      .match_in    (match_chain[i]),
      .staged_next (nb),
      .staged      (staged[i]),
      .match_out   (match_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emit_left <= '0;
      count     <= '0;
      end_pend  <= 1'b0;
    end else if (accept) begin
      count     <= keep;
      end_pend  <= s_tlast;
      out_valid <= result_now;
      emit_left <= (emit != '0) ? emit - CW'(1) : '0;
    end else if (drain_step) begin
      out_valid <= 1'b1;
      emit_left <= emit_left - CW'(1);
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result_now) begin
      out_byte     <= marker ? 8'h00 : staged[0];
      out_has_byte <= ~marker;
      run_last     <= single;
      text_end     <= s_tlast & single;
    end else if (drain_step) begin
      out_byte     <= staged[0];
      out_has_byte <= 1'b1;
      run_last     <= (emit_left == CW'(1));
      text_end     <= end_pend & (emit_left == CW'(1));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = {run_last, out_has_byte};
  assign m_tlast  = text_end;

endmodule
